[hdl/ctlt_pkg.sv]
// ----------------------------------------------------------------------------
// ctlt_pkg
// Widths, side-band bundles and helpers shared by the cell lower-triangular
// datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctlt_pkg;

    localparam int DW  = 32;   // Q16.16 field width
    localparam int EW  = 32;   // Q2.30 frame component width
    localparam int NB  = 31;   // result bits of one frame component
    localparam int SW  = 200;  // squared-norm width
    localparam int PW  = 266;  // recurrence accumulator width
    localparam int MW  = 128;  // wide multiplier operand width
    localparam int LB  = MW / 32;
    localparam int ML  = 5;    // wide multiplier stages
    localparam int FE  = 2 + ML + 1 + ML + 1;   // front stages
    localparam int LAT = FE + NB + 2;
    localparam int IW  = 9 * DW;
    localparam int OW  = 6 * DW;

    typedef logic signed [DW-1:0] fix_t;
    typedef logic signed [EW-1:0] unit_t;

    typedef struct packed {
        logic [IW-1:0]     abc;
        logic [2:0][63:0]  asq;
        logic [63:0]       aa;
        logic [2:0]        xneg;
        logic              deg;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic [2:0][129:0] xsq;
        logic [131:0]      s3;
        logic [2:0]        qneg;
    } mid_t;

    function automatic fix_t fld(input logic [IW-1:0] v, input int i);
        return v[DW*i +: DW];
    endfunction

    function automatic fix_t round_sat(input logic signed [63:0] p0,
                                       input logic signed [63:0] p1,
                                       input logic signed [63:0] p2);
        logic signed [66:0] t;
        logic signed [36:0] q;
        t = $signed({{3{p0[63]}}, p0}) + $signed({{3{p1[63]}}, p1})
          + $signed({{3{p2[63]}}, p2}) + 67'sd536870912;
        q = t[66:30];
        if (q > 37'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (q < -37'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return q[31:0];
        end
    endfunction

endpackage

[hdl/ctlt_norm.sv]
// ----------------------------------------------------------------------------
// ctlt_norm
// One frame component round(2^30 * q / sqrt(s)), one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctlt_norm import ctlt_pkg::*; (
    input  logic              aclk,
    input  logic              adv,
    input  logic [SW-1:0]     s_in,
    input  logic [SW-1:0]     msq_in,
    input  logic              neg_in,
    output unit_t             e_out
);

    logic [NB-1:0]        t_reg   [NB];
    logic signed [PW-1:0] p_reg   [NB];
    logic signed [PW-1:0] q_reg   [NB];
    logic signed [PW-1:0] r_reg   [NB];
    logic [SW-1:0]        s_reg   [NB];
    logic                 neg_reg [NB];

    logic [NB-1:0]        t_w   [NB+1];
    logic signed [PW-1:0] p_w   [NB+1];
    logic signed [PW-1:0] q_w   [NB+1];
    logic signed [PW-1:0] r_w   [NB+1];
    logic [SW-1:0]        s_w   [NB+1];
    logic                 neg_w [NB+1];

    assign t_w[0]   = '0;
    assign p_w[0]   = $signed({{(PW-SW){1'b0}}, s_in});
    assign q_w[0]   = -$signed({{(PW-SW){1'b0}}, s_in});
    assign r_w[0]   = $signed({{(PW-SW-62){1'b0}}, msq_in, 62'b0});
    assign s_w[0]   = s_in;
    assign neg_w[0] = neg_in;

    for (genvar j = 0; j < NB; j++) begin : g_stage
        localparam int K = NB - 1 - j;
        logic signed [PW-1:0] s_ext;
        logic signed [PW-1:0] p_try;
        logic signed [PW-1:0] q_try;
        logic                 take;

        assign s_ext = $signed({{(PW-SW){1'b0}}, s_w[j]});
        assign p_try = p_w[j] + (q_w[j] <<< (K + 2)) + (s_ext <<< (2 * K + 2));
        assign q_try = q_w[j] + (s_ext <<< (K + 1));
        assign take  = (p_try <= r_w[j]);

        always_ff @(posedge aclk) begin
            if (adv) begin
                t_reg[j]   <= take ? (t_w[j] | (NB'(1) << K)) : t_w[j];
                p_reg[j]   <= take ? p_try : p_w[j];
                q_reg[j]   <= take ? q_try : q_w[j];
                r_reg[j]   <= r_w[j];
                s_reg[j]   <= s_w[j];
                neg_reg[j] <= neg_w[j];
            end
        end

        assign t_w[j+1]   = t_reg[j];
        assign p_w[j+1]   = p_reg[j];
        assign q_w[j+1]   = q_reg[j];
        assign r_w[j+1]   = r_reg[j];
        assign s_w[j+1]   = s_reg[j];
        assign neg_w[j+1] = neg_reg[j];
    end

    assign e_out = neg_w[NB] ? -$signed({1'b0, t_w[NB]}) : $signed({1'b0, t_w[NB]});

endmodule

[hdl/cell_to_lower_triangular_unit.sv]
// ----------------------------------------------------------------------------
// cell_to_lower_triangular_unit
// Stages: 2 product/sum stages, two 5-stage wide multiplies each followed by a
// difference or sum stage, 31 stages of the bit-per-stage normalization
// recurrence, 2 projection stages.
// Throughput: one transfer per cycle; a stalled output holds the whole pipeline.
// Reset: synchronous, clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cell_to_lower_triangular_unit import ctlt_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [IW-1:0] s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [OW-1:0] m_tdata,   // l_aa, l_ba, l_bb, l_ca, l_cb, l_cc
    output logic [0:0]    m_tuser    // degenerate
);

    localparam int ROW [6]   = '{0, 1, 1, 2, 2, 2};
    localparam int FRAME [6] = '{0, 0, 1, 0, 1, 2};

    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    logic [IW-1:0]       s1_abc_reg;
    logic signed [63:0]  s1_crp_reg [3];
    logic signed [63:0]  s1_crn_reg [3];
    logic signed [63:0]  s1_ab_reg  [3];
    logic [2:0][63:0]    s1_asq_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_abc_reg <= s_tdata;
            for (int k = 0; k < 3; k++) begin
                s1_crp_reg[k] <= 64'(fld(s_tdata, (k + 1) % 3))
                               * 64'(fld(s_tdata, 3 + (k + 2) % 3));
                s1_crn_reg[k] <= 64'(fld(s_tdata, (k + 2) % 3))
                               * 64'(fld(s_tdata, 3 + (k + 1) % 3));
                s1_ab_reg[k]  <= 64'(fld(s_tdata, k)) * 64'(fld(s_tdata, 3 + k));
                s1_asq_reg[k] <= 64'(fld(s_tdata, k)) * 64'(fld(s_tdata, k));
            end
        end
    end

    logic signed [64:0] x_w [3];
    for (genvar k = 0; k < 3; k++) begin : g_cross
        assign x_w[k] = $signed({s1_crp_reg[k][63], s1_crp_reg[k]})
                      - $signed({s1_crn_reg[k][63], s1_crn_reg[k]});
    end

    logic [IW-1:0]      s2_abc_reg;
    logic signed [64:0] s2_x_reg [3];
    logic [63:0]        s2_aa_reg;
    logic signed [65:0] s2_ab_reg;
    logic [2:0][63:0]   s2_asq_reg;
    logic               s2_deg_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_abc_reg <= s1_abc_reg;
            s2_x_reg   <= x_w;
            s2_asq_reg <= s1_asq_reg;
            s2_aa_reg  <= s1_asq_reg[0] + s1_asq_reg[1] + s1_asq_reg[2];
            s2_ab_reg  <= $signed({{2{s1_ab_reg[0][63]}}, s1_ab_reg[0]})
                        + $signed({{2{s1_ab_reg[1][63]}}, s1_ab_reg[1]})
                        + $signed({{2{s1_ab_reg[2][63]}}, s1_ab_reg[2]});
            s2_deg_reg <= (x_w[0] == '0) && (x_w[1] == '0) && (x_w[2] == '0);
        end
    end

    logic signed [2*MW-1:0] p_w   [3];
    logic signed [2*MW-1:0] r_w   [3];
    logic signed [2*MW-1:0] xsq_w [3];

    for (genvar k = 0; k < 3; k++) begin : g_mul1
        ctlt_mul u_p (
            .aclk  (aclk),
            .adv   (adv),
            .a_in  ({64'b0, s2_aa_reg}),
            .b_in  ({{(MW-DW){s2_abc_reg[DW*(3+k)+DW-1]}}, s2_abc_reg[DW*(3+k) +: DW]}),
            .p_out (p_w[k])
        );
        ctlt_mul u_r (
            .aclk  (aclk),
            .adv   (adv),
            .a_in  ({{(MW-66){s2_ab_reg[65]}}, s2_ab_reg}),
            .b_in  ({{(MW-DW){s2_abc_reg[DW*k+DW-1]}}, s2_abc_reg[DW*k +: DW]}),
            .p_out (r_w[k])
        );
        ctlt_mul u_x (
            .aclk  (aclk),
            .adv   (adv),
            .a_in  ({{(MW-65){s2_x_reg[k][64]}}, s2_x_reg[k]}),
            .b_in  ({{(MW-65){s2_x_reg[k][64]}}, s2_x_reg[k]}),
            .p_out (xsq_w[k])
        );
    end

    side_t sa_reg [ML];

    always_ff @(posedge aclk) begin
        if (adv) begin
            sa_reg[0].abc  <= s2_abc_reg;
            sa_reg[0].asq  <= s2_asq_reg;
            sa_reg[0].aa   <= s2_aa_reg;
            sa_reg[0].xneg <= {s2_x_reg[2][64], s2_x_reg[1][64], s2_x_reg[0][64]};
            sa_reg[0].deg  <= s2_deg_reg;
            for (int i = 1; i < ML; i++) begin
                sa_reg[i] <= sa_reg[i-1];
            end
        end
    end

    side_t              s8_side_reg;
    logic signed [98:0] s8_q_reg [3];
    logic [2:0][129:0]  s8_xsq_reg;
    logic [131:0]       s8_s3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s8_side_reg <= sa_reg[ML-1];
            s8_s3_reg   <= 132'(xsq_w[0][129:0]) + 132'(xsq_w[1][129:0])
                         + 132'(xsq_w[2][129:0]);
            for (int k = 0; k < 3; k++) begin
                s8_q_reg[k]   <= p_w[k][98:0] - r_w[k][98:0];
                s8_xsq_reg[k] <= xsq_w[k][129:0];
            end
        end
    end

    logic signed [2*MW-1:0] qsq_w [3];

    for (genvar k = 0; k < 3; k++) begin : g_mul2
        ctlt_mul u_q (
            .aclk  (aclk),
            .adv   (adv),
            .a_in  ({{(MW-99){s8_q_reg[k][98]}}, s8_q_reg[k]}),
            .b_in  ({{(MW-99){s8_q_reg[k][98]}}, s8_q_reg[k]}),
            .p_out (qsq_w[k])
        );
    end

    mid_t sb_reg [ML];

    always_ff @(posedge aclk) begin
        if (adv) begin
            sb_reg[0].side <= s8_side_reg;
            sb_reg[0].xsq  <= s8_xsq_reg;
            sb_reg[0].s3   <= s8_s3_reg;
            sb_reg[0].qneg <= {s8_q_reg[2][98], s8_q_reg[1][98], s8_q_reg[0][98]};
            for (int i = 1; i < ML; i++) begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    mid_t              fe_mid_reg;
    logic [2:0][197:0] fe_qsq_reg;
    logic [SW-1:0]     fe_s2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            fe_mid_reg <= sb_reg[ML-1];
            fe_s2_reg  <= SW'(qsq_w[0][197:0]) + SW'(qsq_w[1][197:0])
                        + SW'(qsq_w[2][197:0]);
            for (int k = 0; k < 3; k++) begin
                fe_qsq_reg[k] <= qsq_w[k][197:0];
            end
        end
    end

    unit_t e_w [3][3];

    for (genvar k = 0; k < 3; k++) begin : g_frame
        ctlt_norm u_e1 (
            .aclk   (aclk),
            .adv    (adv),
            .s_in   (SW'(fe_mid_reg.side.aa)),
            .msq_in (SW'(fe_mid_reg.side.asq[k])),
            .neg_in (fe_mid_reg.side.abc[DW*k + DW-1]),
            .e_out  (e_w[0][k])
        );
        ctlt_norm u_e2 (
            .aclk   (aclk),
            .adv    (adv),
            .s_in   (fe_s2_reg),
            .msq_in (SW'(fe_qsq_reg[k])),
            .neg_in (fe_mid_reg.qneg[k]),
            .e_out  (e_w[1][k])
        );
        ctlt_norm u_e3 (
            .aclk   (aclk),
            .adv    (adv),
            .s_in   (SW'(fe_mid_reg.s3)),
            .msq_in (SW'(fe_mid_reg.xsq[k])),
            .neg_in (fe_mid_reg.side.xneg[k]),
            .e_out  (e_w[2][k])
        );
    end

    logic [IW-1:0] dl_abc_reg [NB];
    logic          dl_deg_reg [NB];

    always_ff @(posedge aclk) begin
        if (adv) begin
            dl_abc_reg[0] <= fe_mid_reg.side.abc;
            dl_deg_reg[0] <= fe_mid_reg.side.deg;
            for (int i = 1; i < NB; i++) begin
                dl_abc_reg[i] <= dl_abc_reg[i-1];
                dl_deg_reg[i] <= dl_deg_reg[i-1];
            end
        end
    end

    logic signed [63:0] p1_prod_reg [6][3];
    logic               p1_deg_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_deg_reg <= dl_deg_reg[NB-1];
            for (int o = 0; o < 6; o++) begin
                for (int k = 0; k < 3; k++) begin
                    p1_prod_reg[o][k] <= 64'(fld(dl_abc_reg[NB-1], 3 * ROW[o] + k))
                                       * 64'(e_w[FRAME[o]][k]);
                end
            end
        end
    end

    logic [OW-1:0] out_data_reg;
    logic          out_deg_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_deg_reg <= p1_deg_reg;
            for (int o = 0; o < 6; o++) begin
                out_data_reg[DW*o +: DW] <= p1_deg_reg ? '0
                    : round_sat(p1_prod_reg[o][0], p1_prod_reg[o][1], p1_prod_reg[o][2]);
            end
        end
    end

    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_deg_reg;

endmodule

// ----------------------------------------------------------------------------
// ctlt_mul
// Signed wide product in five stages: magnitudes, 32x32 limb products, row
// sums, total, sign.
// ----------------------------------------------------------------------------

module ctlt_mul import ctlt_pkg::*; (
    input  logic                    aclk,
    input  logic                    adv,
    input  logic signed [MW-1:0]    a_in,
    input  logic signed [MW-1:0]    b_in,
    output logic signed [2*MW-1:0]  p_out
);

    localparam int RW  = MW + 32;
    localparam int MPW = 2 * MW;

    logic [MW-1:0]         am_reg;
    logic [MW-1:0]         bm_reg;
    logic [3:0]            neg_reg;
    logic [63:0]           pp_reg  [LB][LB];
    logic [RW-1:0]         row_reg [LB];
    logic [MPW-1:0]        mag_reg;
    logic signed [MPW-1:0] p_reg;

    always_ff @(posedge aclk) begin
        logic [RW-1:0]  row_acc;
        logic [MPW-1:0] mag_acc;
        if (adv) begin
            am_reg  <= a_in[MW-1] ? -a_in : a_in;
            bm_reg  <= b_in[MW-1] ? -b_in : b_in;
            neg_reg <= {neg_reg[2:0], a_in[MW-1] ^ b_in[MW-1]};
            for (int i = 0; i < LB; i++) begin
                for (int j = 0; j < LB; j++) begin
                    pp_reg[i][j] <= 64'(am_reg[32*i +: 32]) * 64'(bm_reg[32*j +: 32]);
                end
            end
            for (int i = 0; i < LB; i++) begin
                row_acc = '0;
                for (int j = 0; j < LB; j++) begin
                    row_acc = row_acc + (RW'(pp_reg[i][j]) << (32 * j));
                end
                row_reg[i] <= row_acc;
            end
            mag_acc = '0;
            for (int i = 0; i < LB; i++) begin
                mag_acc = mag_acc + (MPW'(row_reg[i]) << (32 * i));
            end
            mag_reg <= mag_acc;
            p_reg   <= neg_reg[3] ? -$signed(mag_reg) : $signed(mag_reg);
        end
    end

    assign p_out = p_reg;

endmodule

[hdl/ctlt_checker.sv]
// ----------------------------------------------------------------------------
// ctlt_checker
// Port-level properties of the cell lower-triangular unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctlt_checker import ctlt_pkg::*; (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic [IW-1:0] s_tdata,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [OW-1:0] m_tdata,
    input logic [0:0]    m_tuser
);

    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not track output stall");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("degenerate result carries nonzero data");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind cell_to_lower_triangular_unit ctlt_checker u_ctlt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[sim/ctlt_checker.sv]
// ----------------------------------------------------------------------------
// ctlt_scoreboard
// Watches both stream channels of the cell lower-triangular unit. For every
// input transfer it builds the orthonormal frame in exact wide arithmetic,
// projects the rows onto it and queues the expected lower-triangular entries.
// Every output transfer is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctlt_scoreboard import ctlt_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [IW-1:0] s_tdata,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [OW-1:0] m_tdata,
    input  logic [0:0]    m_tuser,
    output int            fail_count,
    output int            pending
);

    typedef logic signed [319:0] wide_t;

    typedef struct {
        fix_t l [6];
        logic degen;
    } tri_t;

    tri_t expected_tri [$];
    int   out_index;

    // round(2^30 * q / sqrt(s)), ties away from zero
    function automatic longint unit_comp(input wide_t qv, input wide_t s);
        logic [319:0] m;
        logic [319:0] rhs;
        logic [319:0] lhs;
        longint lo;
        longint hi;
        longint mid;
        m   = qv[319] ? -qv : qv;
        rhs = (m * m) << 62;
        lo  = 0;
        hi  = 64'd1073741825;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            lhs = 2 * mid - 1;
            lhs = lhs * lhs * s;
            if (lhs <= rhs) lo = mid;
            else hi = mid;
        end
        return qv[319] ? -lo : lo;
    endfunction

    function automatic fix_t along(input fix_t r [3], input longint e [3]);
        longint t;
        t = longint'(r[0]) * e[0] + longint'(r[1]) * e[1] + longint'(r[2]) * e[2];
        t = (t + 64'sd536870912) >>> 30;
        if (t > 64'sd2147483647) return 32'sh7fffffff;
        if (t < -64'sd2147483648) return 32'sh80000000;
        return t[31:0];
    endfunction

    function automatic tri_t lower_form(input logic [IW-1:0] d);
        tri_t   res;
        fix_t   a [3];
        fix_t   b [3];
        fix_t   c [3];
        wide_t  wa [3];
        wide_t  wb [3];
        wide_t  x [3];
        wide_t  q [3];
        wide_t  aa;
        wide_t  ab;
        wide_t  s2;
        wide_t  s3;
        longint e1 [3];
        longint e2 [3];
        longint e3 [3];
        for (int k = 0; k < 3; k++) begin
            a[k]  = d[DW*k +: DW];
            b[k]  = d[DW*(3+k) +: DW];
            c[k]  = d[DW*(6+k) +: DW];
            wa[k] = a[k];
            wb[k] = b[k];
        end
        for (int k = 0; k < 3; k++) begin
            x[k] = wa[(k+1)%3] * wb[(k+2)%3] - wa[(k+2)%3] * wb[(k+1)%3];
        end
        res.degen = 1'b0;
        if (x[0] == 0 && x[1] == 0 && x[2] == 0) begin
            for (int k = 0; k < 6; k++) res.l[k] = '0;
            res.degen = 1'b1;
            return res;
        end
        aa = 0;
        ab = 0;
        for (int k = 0; k < 3; k++) begin
            aa = aa + wa[k] * wa[k];
            ab = ab + wa[k] * wb[k];
        end
        s2 = 0;
        s3 = 0;
        for (int k = 0; k < 3; k++) begin
            q[k] = aa * wb[k] - ab * wa[k];
            s2   = s2 + q[k] * q[k];
            s3   = s3 + x[k] * x[k];
        end
        for (int k = 0; k < 3; k++) begin
            e1[k] = unit_comp(wa[k], aa);
            e2[k] = unit_comp(q[k], s2);
            e3[k] = unit_comp(x[k], s3);
        end
        res.l[0] = along(a, e1);
        res.l[1] = along(b, e1);
        res.l[2] = along(b, e2);
        res.l[3] = along(c, e1);
        res.l[4] = along(c, e2);
        res.l[5] = along(c, e3);
        return res;
    endfunction

    task automatic report(input string what, input int idx, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch: transfer %0d %s got %h expected %h", idx, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        out_index  = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        tri_t want;
        if (aresetn && s_tvalid && s_tready) begin
            expected_tri.push_back(lower_form(s_tdata));
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tri.size() == 0) begin
                report("unexpected", out_index, m_tdata[31:0], '0);
            end else begin
                want = expected_tri.pop_front();
                for (int k = 0; k < 6; k++) begin
                    if (m_tdata[DW*k +: DW] !== want.l[k]) begin
                        report($sformatf("l[%0d]", k), out_index, m_tdata[DW*k +: DW],
                               want.l[k]);
                    end
                end
                if (m_tuser[0] !== want.degen) begin
                    report("degenerate", out_index, 32'(m_tuser), 32'(want.degen));
                end
            end
            out_index++;
        end
        pending = expected_tri.size();
    end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the cell lower-triangular unit: directed corner
// cells (zero, parallel rows, extremes, saturation) then random cells, run
// through phases of sender gaps and receiver stalls plus one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import ctlt_pkg::*;;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [IW-1:0] s_tdata;   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    logic          m_tvalid;
    logic          m_tready;
    logic [OW-1:0] m_tdata;   // l_aa, l_ba, l_bb, l_ca, l_cb, l_cc
    logic [0:0]    m_tuser;   // degenerate

    int fail_count;
    int pending;
    int phase;
    int sent;
    int hold_left;
    bit hold_done;

    localparam fix_t PMAX = 32'sh7fffffff;
    localparam fix_t NMAX = 32'sh80000000;
    localparam fix_t ONE  = 32'sh00010000;

    cell_to_lower_triangular_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ctlt_scoreboard u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // receiver: random stalls per phase, one long hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && sent >= 60) begin
            m_tready  <= 1'b0;
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (phase == 2) begin
            m_tready <= ($urandom_range(99) >= 77);
        end else if (phase == 3) begin
            m_tready <= ($urandom_range(99) >= 20);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_cell(input fix_t a [3], input fix_t b [3], input fix_t c [3]);
        int idle_pct;
        idle_pct = (phase == 1) ? 77 : (phase == 3) ? 20 : 0;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c[2], c[1], c[0], b[2], b[1], b[0], a[2], a[1], a[0]};
        do @(posedge aclk); while (!s_tready);
        sent++;
        @(negedge aclk);
    endtask

    function automatic fix_t rand_fix(input int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(65535)) - 32768;
            2: return $signed($urandom_range(2000000)) - 1000000;
            default: return ($urandom_range(1)) ? PMAX : NMAX;
        endcase
    endfunction

    task automatic random_cell();
        fix_t a [3];
        fix_t b [3];
        fix_t c [3];
        int   mode;
        int   kind;
        int   f;
        mode = $urandom_range(3);
        if (mode == 3 && $urandom_range(3) != 0) mode = 0;
        kind = $urandom_range(9);
        for (int k = 0; k < 3; k++) begin
            a[k] = rand_fix(mode);
            b[k] = rand_fix(mode);
            c[k] = rand_fix(mode);
        end
        if (kind == 0) begin
            // b parallel to a
            f = $signed($urandom_range(8)) - 4;
            for (int k = 0; k < 3; k++) begin
                a[k] = rand_fix(1);
                b[k] = a[k] * f;
            end
        end else if (kind == 1) begin
            for (int k = 0; k < 3; k++) a[k] = '0;
        end
        send_cell(a, b, c);
    endtask

    initial begin
        fix_t z [3];
        fix_t p [3];
        fix_t n [3];
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        aresetn   = 1'b0;
        phase     = 0;
        sent      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        z = '{32'sd0, 32'sd0, 32'sd0};
        p = '{PMAX, PMAX, PMAX};
        n = '{NMAX, NMAX, NMAX};
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        send_cell(z, z, z);
        send_cell(z, p, n);
        send_cell(p, p, p);
        send_cell(n, n, n);
        send_cell(p, n, p);
        send_cell('{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, ONE});
        send_cell('{ONE, 0, 0}, '{2 * ONE, 0, 0}, '{ONE, ONE, ONE});
        send_cell('{PMAX, 0, 0}, '{0, PMAX, 0}, p);
        send_cell('{PMAX, 0, 0}, '{0, NMAX, 0}, n);
        send_cell('{NMAX, 0, 0}, '{0, 0, PMAX}, '{PMAX, NMAX, PMAX});
        send_cell('{ONE, ONE, ONE}, '{ONE, ONE, -ONE}, p);
        send_cell('{32'sd1, 0, 0}, '{0, 32'sd1, 0}, '{32'sd1, 32'sd1, 32'sd1});
        send_cell('{32'sd1, 32'sd1, 0}, '{32'sd1, -32'sd1, 0}, n);
        send_cell('{-ONE, 0, 0}, '{0, -ONE, 0}, '{0, 0, -ONE});
        send_cell('{32'sd3, 32'sd4, 0}, '{-32'sd4, 32'sd3, 0}, '{0, 0, NMAX});

        for (int i = 0; i < 1000; i++) begin
            phase = (i < 250) ? 0 : (i < 500) ? 1 : (i < 750) ? 2 : 3;
            random_cell();
        end
        s_tvalid <= 1'b0;
        phase = 0;

        while (pending != 0) @(negedge aclk);
        repeat (LAT + 20) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule

[cell_to_lower_triangular_unit.f]
hdl/ctlt_pkg.sv
hdl/ctlt_norm.sv
hdl/cell_to_lower_triangular_unit.sv
hdl/ctlt_checker.sv
sim/ctlt_checker.sv
sim/tb_top.sv
